// ===== rtl/htpid_pkg.sv =====
// ----------------------------------------------------------------------------
// htpid_pkg
// Shared widths, constants and controller/datapath interface types for the
// heater temperature PID block.
// ----------------------------------------------------------------------------
package htpid_pkg;

  // Control runs on each CONTROL_DIVIDE-th present item whose sample is valid.
  localparam int unsigned CONTROL_DIVIDE = 10;
  // PWM counter reload value; the compare value is scaled from the duty.
  localparam int unsigned PWM_LOAD = 1000;

  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Temperature limits, signed Q8.8.
  localparam logic signed [15:0] T_MIN      = -16'sd5120;
  localparam logic signed [15:0] T_READ_MAX = 16'sd25600;
  localparam logic signed [15:0] T_SAFE_MAX = 16'sd21760;

  // Integral clamp, signed Q7.8.
  localparam logic signed [14:0] I_LIMIT     = 15'sd5120;
  localparam logic signed [14:0] I_LIMIT_NEG = -15'sd5120;

  localparam logic [9:0] DUTY_FULL = 10'd1000;

  // Reciprocal of ten for a 14-bit numerator, taken with a 16-bit shift.
  localparam int unsigned DIV10_RECIP = (2 ** 16 + 9) / 10;

  // The compare value needs (duty * PWM_LOAD + 500) / 1000. The load splits
  // into a multiple of 1000 and a remainder; the remainder part is divided
  // by 8 and then by 125 through a reciprocal with a 24-bit shift.
  localparam int unsigned PWM_QUOT   = PWM_LOAD / 1000;
  localparam int unsigned PWM_REM    = PWM_LOAD % 1000;
  localparam int unsigned CMP_RECIP  = (2 ** 24 + 124) / 125;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_FAST_BAND    = 3'd4,
    REG_FILTER_ALPHA = 3'd5,
    REG_READY_TOL    = 3'd6
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic filt_upd;
    logic err_calc;
    logic pid_eval;
    logic pid_mul_i;
    logic pid_mul_d;
    logic pid_add_d;
    logic duty_calc;
    logic cmp_calc;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_pid;
    logic pid_done;
    logic p_only;
  } status_t;

endpackage

// ===== rtl/htpid_dp.sv =====
// ----------------------------------------------------------------------------
// htpid_dp
// Datapath: configuration registers, input capture, low-pass filter, PID
// state with a shared multiplier, duty and PWM compare, result registers.
// ----------------------------------------------------------------------------
module htpid_dp import htpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic signed [15:0]    temp_sample,
  input  logic                  sensor_present,
  input  logic                  read_ok,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [9:0]            duty_permille,
  output logic [9:0]            compare_value,
  output logic                  drive_enabled,
  output logic                  temp_valid,
  output logic signed [15:0]    filtered_temp,
  output logic                  filter_loaded,
  output logic                  control_ran,
  output logic                  ready_res
);

  localparam logic [COUNT_W-1:0] CDIV = COUNT_W'(CONTROL_DIVIDE);

  // Configuration registers.
  logic [14:0] setpoint;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [12:0] fast_band;
  logic [15:0] filter_alpha;
  logic [12:0] ready_tolerance;

  // Captured item.
  logic signed [15:0] smp;
  logic               present;
  logic               rd_ok;

  // Controller-visible state.
  logic signed [23:0]        filter_value;
  logic                      filter_valid_flag;
  logic signed [13:0]        integral_sum;
  logic signed [16:0]        previous_error;
  logic [COUNT_W-1:0]        control_count;
  logic [9:0]                duty_hold;
  logic                      run_pid;
  logic                      p_only;

  // Working registers.
  logic signed [41:0] prod;
  logic signed [41:0] acc;
  logic signed [16:0] e_reg;
  logic signed [21:0] de10;
  logic [16:0]        cmp_base;
  logic [16:0]        cmp_y;
  logic               ready_flag;

  // Combinational terms.
  logic               smp_valid;
  logic               smp_hot;
  logic signed [24:0] smp_scaled;
  logic signed [24:0] filt_diff;
  logic signed [41:0] prod_floor;
  logic signed [23:0] fv_upd;
  logic signed [15:0] filt;
  logic [COUNT_W-1:0] count_inc;
  logic               slot;
  logic signed [17:0] e_full;
  logic signed [16:0] band_pos;
  logic signed [16:0] band_neg;
  logic               cutoff;
  logic               band_hi;
  logic               band_lo;
  logic               prev_pos;
  logic [16:0]        e_mag;
  logic [13:0]        div10_num;
  logic [26:0]        div10_prod;
  logic [10:0]        div10_q;
  logic signed [14:0] inc;
  logic signed [13:0] integ_base;
  logic signed [14:0] integ_sum;
  logic signed [13:0] integ_next;
  logic signed [17:0] de;
  logic signed [21:0] de_ext;
  logic signed [21:0] de10_next;
  logic signed [45:0] acc_ext;
  logic signed [45:0] acc_scaled;
  logic signed [45:0] duty_raw;
  logic [19:0]        cmp_num;
  logic [34:0]        cmp_prod;
  logic [17:0]        cmp_total;
  logic [17:0]        cmp_diff;
  logic [15:0]        mul_a;
  logic signed [24:0] mul_b;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint        <= 15'd12800;
      gain_p          <= 16'd8192;
      gain_i          <= 16'd128;
      gain_d          <= 16'd3584;
      fast_band       <= 13'd768;
      filter_alpha    <= 16'd7864;
      ready_tolerance <= 13'd256;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:     setpoint        <= cfg_data[14:0];
        REG_GAIN_P:       gain_p          <= cfg_data;
        REG_GAIN_I:       gain_i          <= cfg_data;
        REG_GAIN_D:       gain_d          <= cfg_data;
        REG_FAST_BAND:    fast_band       <= cfg_data[12:0];
        REG_FILTER_ALPHA: filter_alpha    <= cfg_data;
        REG_READY_TOL:    ready_tolerance <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Sample checks and the filter step.
  assign smp_valid  = present && rd_ok && (smp > T_MIN) && (smp < T_READ_MAX);
  assign smp_hot    = smp >= T_SAFE_MAX;
  assign smp_scaled = {smp[15], smp, 8'h00};
  assign filt_diff  = smp_scaled - {filter_value[23], filter_value};
  assign prod_floor = prod >>> 16;
  assign fv_upd     = filter_value + prod_floor[23:0];
  assign filt       = filter_value[23:8];

  // Control slot counter.
  assign count_inc = control_count + 1'b1;
  assign slot      = count_inc >= CDIV;

  // Error and band tests.
  assign e_full   = $signed({3'b000, setpoint}) - $signed({{2{filt[15]}}, filt});
  assign band_pos = $signed({4'b0000, fast_band});
  assign band_neg = -band_pos;
  assign cutoff   = (filt <= T_MIN) || (filt >= T_SAFE_MAX);
  assign band_hi  = e_reg > band_pos;
  assign band_lo  = e_reg < band_neg;
  assign prev_pos = previous_error > 17'sd0;
  assign e_mag    = e_reg[16] ? 17'(-e_reg) : e_reg;

  // Integral increment: error over ten, rounded half away from zero.
  assign div10_num  = {1'b0, e_mag[12:0]} + 14'd5;
  assign div10_prod = 27'(div10_num) * 27'(DIV10_RECIP);
  assign div10_q    = div10_prod[26:16];
  assign inc        = e_reg[16] ? -$signed({4'b0000, div10_q}) : $signed({4'b0000, div10_q});
  assign integ_base = (e_reg <= 17'sd0 && prev_pos) ? 14'sd0 : integral_sum;
  assign integ_sum  = $signed({integ_base[13], integ_base}) + inc;

  always_comb begin
    if (integ_sum > I_LIMIT) begin
      integ_next = I_LIMIT[13:0];
    end else if (integ_sum < I_LIMIT_NEG) begin
      integ_next = I_LIMIT_NEG[13:0];
    end else begin
      integ_next = integ_sum[13:0];
    end
  end

  // Derivative term, ten times the error change.
  assign de        = $signed({e_reg[16], e_reg}) - $signed({previous_error[16], previous_error});
  assign de_ext    = {{4{de[17]}}, de};
  assign de10_next = (de_ext <<< 3) + (de_ext <<< 1);

  // Duty from the PID sum: (sum * 10 + 0.5) in Q.16.
  assign acc_ext    = {{4{acc[41]}}, acc};
  assign acc_scaled = (acc_ext <<< 3) + (acc_ext <<< 1) + 46'sd32768;
  assign duty_raw   = acc_scaled >>> 16;

  // PWM compare from the duty.
  assign cmp_num   = 20'(duty_hold) * 20'(PWM_REM) + 20'd500;
  assign cmp_prod  = 35'(cmp_y) * 35'(CMP_RECIP);
  assign cmp_total = 18'(cmp_base) + 18'(cmp_prod[34:24]);
  assign cmp_diff  = 18'(PWM_LOAD) - cmp_total;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = filter_alpha;
    mul_b = filt_diff;
    if (cmd.pid_eval) begin
      mul_a = gain_p;
      mul_b = {{8{e_reg[16]}}, e_reg};
    end else if (cmd.pid_mul_i) begin
      mul_a = gain_i;
      mul_b = {{11{integral_sum[13]}}, integral_sum};
    end else if (cmd.pid_mul_d) begin
      mul_a = gain_d;
      mul_b = {{3{de10[21]}}, de10};
    end
  end

  assign status.run_pid  = run_pid;
  assign status.pid_done = cutoff || band_hi;
  assign status.p_only   = p_only;

  // Filter, PID and duty state.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value      <= '0;
      filter_valid_flag <= 1'b0;
      integral_sum      <= '0;
      previous_error    <= '0;
      control_count     <= '0;
      duty_hold         <= '0;
      run_pid           <= 1'b0;
      p_only            <= 1'b0;
    end else begin
      if (cmd.filt_upd) begin
        if (smp_valid) begin
          if (!filter_valid_flag) begin
            filter_value      <= smp_scaled[23:0];
            filter_valid_flag <= 1'b1;
          end else begin
            filter_value <= fv_upd;
          end
        end else begin
          filter_valid_flag <= 1'b0;
        end
        run_pid <= 1'b0;
        if (!present) begin
          integral_sum   <= '0;
          previous_error <= '0;
          duty_hold      <= '0;
        end else begin
          if (!smp_valid || smp_hot) begin
            integral_sum   <= '0;
            previous_error <= '0;
            duty_hold      <= '0;
          end
          if (slot) begin
            control_count <= '0;
            run_pid       <= smp_valid;
          end else begin
            control_count <= count_inc;
          end
        end
      end

      if (cmd.pid_eval) begin
        if (cutoff) begin
          integral_sum   <= '0;
          previous_error <= '0;
          duty_hold      <= '0;
        end else if (band_hi) begin
          integral_sum   <= '0;
          previous_error <= '0;
          duty_hold      <= DUTY_FULL;
        end else if (band_lo) begin
          if (prev_pos) begin
            integral_sum <= '0;
          end
          previous_error <= e_reg;
          p_only         <= 1'b1;
        end else begin
          integral_sum   <= integ_next;
          previous_error <= e_reg;
          p_only         <= 1'b0;
        end
      end

      if (cmd.duty_calc) begin
        if (acc <= 42'sd0) begin
          duty_hold <= '0;
        end else if (duty_raw > $signed(46'(DUTY_FULL))) begin
          duty_hold <= DUTY_FULL;
        end else begin
          duty_hold <= duty_raw[9:0];
        end
      end
    end
  end

  // Working registers and result registers.
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;
    if (cmd.capture) begin
      smp     <= temp_sample;
      present <= sensor_present;
      rd_ok   <= read_ok;
    end
    if (cmd.err_calc) begin
      e_reg <= e_full[16:0];
    end
    if (cmd.pid_eval) begin
      de10 <= de10_next;
    end
    if (cmd.pid_mul_i) begin
      acc <= prod;
    end
    if (cmd.pid_mul_d || cmd.pid_add_d) begin
      acc <= acc + prod;
    end
    if (cmd.cmp_calc) begin
      cmp_base   <= 17'(duty_hold) * 17'(PWM_QUOT);
      cmp_y      <= cmp_num[19:3];
      ready_flag <= smp_valid && filter_valid_flag && (e_mag < {4'b0000, ready_tolerance});
    end
    if (cmd.out_load) begin
      duty_permille <= duty_hold;
      compare_value <= cmp_diff[9:0];
      drive_enabled <= duty_hold != 10'd0;
      temp_valid    <= smp_valid;
      filtered_temp <= filt;
      filter_loaded <= filter_valid_flag;
      control_ran   <= run_pid;
      ready_res     <= ready_flag;
    end
  end

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_hold <= DUTY_FULL)
    else $error("Held duty exceeds full scale.");

  a_integral_clamp: assert property (@(posedge clk) disable iff (rst)
    ($signed({integral_sum[13], integral_sum}) <= I_LIMIT) &&
    ($signed({integral_sum[13], integral_sum}) >= I_LIMIT_NEG))
    else $error("Integral sum outside its clamp.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    control_count < CDIV)
    else $error("Control slot counter past its divide value.");
`endif

endmodule

// ===== rtl/htpid_ctrl.sv =====
// ----------------------------------------------------------------------------
// htpid_ctrl
// Controller: sequences one item through the datapath and owns the input
// and output handshakes.
// ----------------------------------------------------------------------------
module htpid_ctrl import htpid_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_FMUL = 11'b000_0000_0010,
    S_FUPD = 11'b000_0000_0100,
    S_ERR  = 11'b000_0000_1000,
    S_PID0 = 11'b000_0001_0000,
    S_PID1 = 11'b000_0010_0000,
    S_PID2 = 11'b000_0100_0000,
    S_PID3 = 11'b000_1000_0000,
    S_DUTY = 11'b001_0000_0000,
    S_CMP  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_FMUL;
        end
      end
      S_FMUL: begin
        state_next = S_FUPD;
      end
      S_FUPD: begin
        cmd.filt_upd = 1'b1;
        state_next   = S_ERR;
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_next   = status.run_pid ? S_PID0 : S_CMP;
      end
      S_PID0: begin
        cmd.pid_eval = 1'b1;
        state_next   = status.pid_done ? S_CMP : S_PID1;
      end
      S_PID1: begin
        cmd.pid_mul_i = 1'b1;
        state_next    = status.p_only ? S_DUTY : S_PID2;
      end
      S_PID2: begin
        cmd.pid_mul_d = 1'b1;
        state_next    = S_PID3;
      end
      S_PID3: begin
        cmd.pid_add_d = 1'b1;
        state_next    = S_DUTY;
      end
      S_DUTY: begin
        cmd.duty_calc = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_calc = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_space: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("Result register overwritten before its item was taken.");
`endif

endmodule

// ===== rtl/heater_temperature_pid.sv =====
// ----------------------------------------------------------------------------
// heater_temperature_pid
// Each item runs capture, filter and error steps; on a control slot the PID
// step follows, ending early at cutoff or above the band, else going on to
// the gain products and the duty. Throughput: one item at a time, set by
// the controller sequence around the shared multiplier; a result left
// waiting holds the next item in its output step. Synchronous reset loads
// the default gains and clears the filter, PID state, counter and duty.
// ----------------------------------------------------------------------------
module heater_temperature_pid import htpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    temp_sample,
  input  logic                  sensor_present,
  input  logic                  read_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            duty_permille,
  output logic [9:0]            compare_value,
  output logic                  drive_enabled,
  output logic                  temp_valid,
  output logic signed [15:0]    filtered_temp,
  output logic                  filter_loaded,
  output logic                  control_ran,
  output logic                  ready_res,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Sequencer for one item at a time.
  htpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Filter, PID arithmetic and result registers.
  htpid_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .temp_sample    (temp_sample),
    .sensor_present (sensor_present),
    .read_ok        (read_ok),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .duty_permille  (duty_permille),
    .compare_value  (compare_value),
    .drive_enabled  (drive_enabled),
    .temp_valid     (temp_valid),
    .filtered_temp  (filtered_temp),
    .filter_loaded  (filter_loaded),
    .control_ran    (control_ran),
    .ready_res      (ready_res)
  );

endmodule
